// ----- design/lmsd_pkg.sv -----
package lmsd_pkg;

    // Fixed geometry of the wired matrix.
    localparam int SCAN_ROWS = 3;
    localparam int SCAN_COLS = 9;
    localparam int GRID_SIDE = 5;
    localparam int DOT_COUNT = GRID_SIDE * GRID_SIDE;

    // Opcodes
    localparam logic [2:0] OP_SET     = 3'd0;
    localparam logic [2:0] OP_CLR     = 3'd1;
    localparam logic [2:0] OP_TGL     = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_CLR_ALL = 3'd4;

    typedef logic [SCAN_COLS-1:0]         t_col_word;
    typedef logic [SCAN_ROWS-1:0]         t_row_word;
    typedef logic [$clog2(SCAN_ROWS)-1:0] t_row_idx;
    typedef logic [$clog2(SCAN_COLS)-1:0] t_col_idx;
    typedef logic [$clog2(DOT_COUNT)-1:0] t_dot_idx;

    typedef struct packed {
        t_row_idx row;
        t_col_idx col;
    } t_dot_map;

    // Controller to datapath command
    typedef struct packed {
        logic exec;
    } t_cmd;

    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } t_state;

    // Dot index (x + y*GRID_SIDE) to zero-based row/column line.
    function automatic t_dot_map dot_map(t_dot_idx idx);
        t_dot_map m;
        case (idx)
            5'd0:    m = '{row: 2'd0, col: 4'd0};
            5'd1:    m = '{row: 2'd2, col: 4'd3};
            5'd2:    m = '{row: 2'd1, col: 4'd1};
            5'd3:    m = '{row: 2'd0, col: 4'd7};
            5'd4:    m = '{row: 2'd2, col: 4'd2};
            5'd5:    m = '{row: 2'd1, col: 4'd3};
            5'd6:    m = '{row: 2'd2, col: 4'd4};
            5'd7:    m = '{row: 2'd0, col: 4'd8};
            5'd8:    m = '{row: 2'd0, col: 4'd6};
            5'd9:    m = '{row: 2'd1, col: 4'd6};
            5'd10:   m = '{row: 2'd0, col: 4'd1};
            5'd11:   m = '{row: 2'd2, col: 4'd5};
            5'd12:   m = '{row: 2'd1, col: 4'd2};
            5'd13:   m = '{row: 2'd0, col: 4'd5};
            5'd14:   m = '{row: 2'd2, col: 4'd0};
            5'd15:   m = '{row: 2'd1, col: 4'd4};
            5'd16:   m = '{row: 2'd2, col: 4'd6};
            5'd17:   m = '{row: 2'd2, col: 4'd8};
            5'd18:   m = '{row: 2'd0, col: 4'd4};
            5'd19:   m = '{row: 2'd1, col: 4'd5};
            5'd20:   m = '{row: 2'd0, col: 4'd2};
            5'd21:   m = '{row: 2'd2, col: 4'd7};
            5'd22:   m = '{row: 2'd1, col: 4'd0};
            5'd23:   m = '{row: 2'd0, col: 4'd3};
            5'd24:   m = '{row: 2'd2, col: 4'd1};
            default: m = '{row: 2'd0, col: 4'd0};
        endcase
        return m;
    endfunction

endpackage

// ----- design/lmsd_if.sv -----
interface lmsd_in_if;
    import lmsd_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [2:0] x_coord;
    logic [2:0] y_coord;

    modport source (output valid, output opcode, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input opcode, input x_coord, input y_coord, output ready);
endinterface

interface lmsd_out_if;
    import lmsd_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] row_drive;
    logic [8:0] col_drive;
    logic       scan_active;

    modport source (output valid, output row_drive, output col_drive, output scan_active,
                    input ready);
    modport sink   (input valid, input row_drive, input col_drive, input scan_active,
                    output ready);
endinterface

// ----- design/led_matrix_mapped_scan_driver_core.sv -----
// LED matrix scan driver: a 5x5 dot grid mapped onto 3 row lines x 9 column lines.
//
// Input channel i_in carries one command per transfer: opcode (set, clear,
// toggle dot, scan tick, clear all) with x_coord / y_coord. Coordinates of 5
// or more make a dot command a no-op. Output channel o_out returns one result
// per command: the row and column line levels and scan_active, as they stand
// after the command. Columns are active low; a blank frame shows rows all low
// and columns all high.
//
// Latency: result valid the cycle after the input transfer. Throughput: one
// command per cycle; the single result register is refilled in the same
// cycle it is taken, so i_in.ready = result slot empty or o_out.ready.
// If the receiver stalls, the result holds and input stalls behind it.
//
// Reset (synchronous, active low): frame store cleared, scan stopped, row
// pointer zero, lines blank, no result pending.
module led_matrix_mapped_scan_driver_core import lmsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lmsd_in_if.sink    i_in,
    lmsd_out_if.source o_out
);

    t_cmd cmd;
    logic in_ready;
    logic out_valid;

    // Handshake control: one result slot, refilled on the same edge it drains.
    lmsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Frame store, scan pointer and the line registers, which double as the
    // result register.
    lmsd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_in.opcode),
        .i_x_coord     (i_in.x_coord),
        .i_y_coord     (i_in.y_coord),
        .o_row_drive   (o_out.row_drive),
        .o_col_drive   (o_out.col_drive),
        .o_scan_active (o_out.scan_active)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ----- design/lmsd_ctrl.sv -----
module lmsd_ctrl import lmsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    // Result slot frees when taken; a new transfer may land the same cycle.
    always_comb begin
        o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
        o_out_valid = (r_state == ST_FULL);
        o_cmd.exec  = i_in_valid && o_in_ready;
        n_state     = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (o_cmd.exec) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (o_cmd.exec)       n_state = ST_FULL;
                else if (i_out_ready) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

endmodule

// ----- design/lmsd_dpath.sv -----
module lmsd_dpath import lmsd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  logic [2:0] i_opcode,
    input  logic [2:0] i_x_coord,
    input  logic [2:0] i_y_coord,
    output t_row_word o_row_drive,
    output t_col_word o_col_drive,
    output logic      o_scan_active
);

    t_col_word r_frame [SCAN_ROWS];
    t_col_word n_frame [SCAN_ROWS];
    t_row_idx  r_scan_idx, n_scan_idx;
    logic      r_running, n_running;
    t_row_word r_rows, n_rows;
    t_col_word r_cols, n_cols;

    logic      in_grid;
    t_dot_idx  dot_idx;
    t_dot_map  map;
    t_col_word bit_mask;
    t_col_word upd_word;
    logic      others_lit;
    logic      now_empty;
    t_row_idx  tick_row;

    assign in_grid  = (i_x_coord < 3'(GRID_SIDE)) && (i_y_coord < 3'(GRID_SIDE));
    assign dot_idx  = t_dot_idx'(i_x_coord) + t_dot_idx'(i_y_coord) * t_dot_idx'(GRID_SIDE);
    assign map      = dot_map(dot_idx);
    assign bit_mask = t_col_word'(1) << map.col;
    assign tick_row = (r_scan_idx >= t_row_idx'(SCAN_ROWS)) ? '0 : r_scan_idx;

    always_comb begin
        upd_word = r_frame[map.row];
        case (i_opcode)
            OP_SET:  upd_word = r_frame[map.row] | bit_mask;
            OP_CLR:  upd_word = r_frame[map.row] & ~bit_mask;
            default: upd_word = r_frame[map.row] ^ bit_mask;
        endcase
    end

    always_comb begin
        others_lit = 1'b0;
        for (int r = 0; r < SCAN_ROWS; r++) begin
            if ((t_row_idx'(r) != map.row) && (r_frame[t_row_idx'(r)] != '0)) others_lit = 1'b1;
        end
    end

    assign now_empty = !others_lit && (upd_word == '0);

    always_comb begin
        n_frame    = r_frame;
        n_scan_idx = r_scan_idx;
        n_running  = r_running;
        n_rows     = r_rows;
        n_cols     = r_cols;
        case (i_opcode)
            OP_SET, OP_CLR, OP_TGL: begin
                if (in_grid) begin
                    n_frame[map.row] = upd_word;
                    if (i_opcode == OP_SET) begin
                        n_running = 1'b1;
                    end else if (now_empty) begin
                        n_running = 1'b0;
                        n_rows    = '0;
                        n_cols    = '1;
                    end else if (i_opcode == OP_TGL) begin
                        n_running = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_running) begin
                    n_rows     = t_row_word'(1) << tick_row;
                    n_cols     = ~r_frame[tick_row];
                    n_scan_idx = (tick_row == t_row_idx'(SCAN_ROWS - 1)) ? '0
                                                                         : tick_row + t_row_idx'(1);
                end
            end
            OP_CLR_ALL: begin
                for (int r = 0; r < SCAN_ROWS; r++) n_frame[t_row_idx'(r)] = '0;
                n_running = 1'b0;
                n_rows    = '0;
                n_cols    = '1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SCAN_ROWS; r++) r_frame[t_row_idx'(r)] <= '0;
            r_scan_idx <= '0;
            r_running  <= 1'b0;
            r_rows     <= '0;
            r_cols     <= '1;
        end else if (i_cmd.exec) begin
            r_frame    <= n_frame;
            r_scan_idx <= n_scan_idx;
            r_running  <= n_running;
            r_rows     <= n_rows;
            r_cols     <= n_cols;
        end
    end

    assign o_row_drive   = r_rows;
    assign o_col_drive   = r_cols;
    assign o_scan_active = r_running;

`ifndef SYNTH
    // Scan runs exactly while some dot is lit.
    a_run_iff_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running == ((r_frame[0] != '0) || (r_frame[1] != '0) || (r_frame[2] != '0)))
        else $error("scan state disagrees with frame contents");

    // Stopped scan always shows blank lines.
    a_blank_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_rows == '0) && (r_cols == '1))
        else $error("lines not blank while scan stopped");

    // At most one row driven; row pointer stays in range.
    a_row_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_rows) && (r_scan_idx < t_row_idx'(SCAN_ROWS)))
        else $error("row drive or scan pointer out of range");
`endif

endmodule

// ----- dv/lmsd_line_checker.sv -----
module lmsd_line_checker import lmsd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    lmsd_in_if   i_cmd,
    lmsd_out_if  i_lines,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_row_word rows;
        t_col_word cols;
        logic      active;
    } t_line_state;

    // Dot wiring, index x + y*GRID_SIDE: {row line, column line}, both 1-based.
    localparam logic [0:DOT_COUNT-1][7:0] DOT_WIRING = {
        8'h11, 8'h34, 8'h22, 8'h18, 8'h33,
        8'h24, 8'h35, 8'h19, 8'h17, 8'h27,
        8'h12, 8'h36, 8'h23, 8'h16, 8'h31,
        8'h25, 8'h37, 8'h39, 8'h15, 8'h26,
        8'h13, 8'h38, 8'h21, 8'h14, 8'h32
    };

    t_col_word   frame [SCAN_ROWS];
    int unsigned next_row;
    logic        running;
    t_row_word   row_lines;
    t_col_word   col_lines;
    t_line_state expected_lines [$];
    int          fail_count = 0;

    function automatic logic frame_lit();
        logic lit;
        lit = 1'b0;
        for (int r = 0; r < SCAN_ROWS; r++) begin
            lit = lit | (|frame[r]);
        end
        return lit;
    endfunction

    task automatic go_dark();
        running   = 1'b0;
        row_lines = '0;
        col_lines = '1;
    endtask

    task automatic clear_matrix();
        for (int r = 0; r < SCAN_ROWS; r++) begin
            frame[r] = '0;
        end
        next_row = 0;
        go_dark();
    endtask

    // Advances the matrix state by one command and returns the line levels after it.
    task automatic advance_matrix(input logic [2:0] op, input logic [2:0] x,
                                  input logic [2:0] y, output t_line_state lines);
        int idx;
        int r;
        int c;
        case (op)
            OP_SET, OP_CLR, OP_TGL: begin
                if (x < GRID_SIDE && y < GRID_SIDE) begin
                    idx = int'(x) + int'(y) * GRID_SIDE;
                    r   = int'(DOT_WIRING[idx][7:4]) - 1;
                    c   = int'(DOT_WIRING[idx][3:0]) - 1;
                    if (op == OP_SET) begin
                        frame[r][c] = 1'b1;
                        running     = 1'b1;
                    end else begin
                        frame[r][c] = (op == OP_TGL) ? ~frame[r][c] : 1'b0;
                        if (!frame_lit()) begin
                            go_dark();
                        end else if (op == OP_TGL) begin
                            running = 1'b1;
                        end
                    end
                end
            end
            OP_TICK: begin
                if (running) begin
                    if (next_row >= SCAN_ROWS) begin
                        next_row = 0;
                    end
                    row_lines           = '0;
                    row_lines[next_row] = 1'b1;
                    col_lines           = ~frame[next_row];
                    next_row            = (next_row + 1 >= SCAN_ROWS) ? 0 : next_row + 1;
                end
            end
            OP_CLR_ALL: begin
                for (int k = 0; k < SCAN_ROWS; k++) begin
                    frame[k] = '0;
                end
                go_dark();
            end
            default: begin
            end
        endcase
        lines = '{rows: row_lines, cols: col_lines, active: running};
    endtask

    task automatic note_failure(input string what, input int want, input int got);
        if (fail_count < MAX_REPORTS) begin
            $display("line mismatch on %s: expected %0h, got %0h", what, want, got);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_line_state want;
        t_line_state next_lines;
        if (!i_rst_n) begin
            clear_matrix();
            expected_lines.delete();
        end else begin
            // A result always belongs to an earlier command, so retire first.
            if (i_lines.valid && i_lines.ready) begin
                if (expected_lines.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("result with no command pending: rows %0h cols %0h active %0b",
                                 i_lines.row_drive, i_lines.col_drive, i_lines.scan_active);
                    end
                    fail_count++;
                end else begin
                    want = expected_lines.pop_front();
                    if (i_lines.row_drive !== want.rows) begin
                        note_failure("row_drive", want.rows, i_lines.row_drive);
                    end
                    if (i_lines.col_drive !== want.cols) begin
                        note_failure("col_drive", want.cols, i_lines.col_drive);
                    end
                    if (i_lines.scan_active !== want.active) begin
                        note_failure("scan_active", want.active, i_lines.scan_active);
                    end
                end
            end
            if (i_cmd.valid && i_cmd.ready) begin
                advance_matrix(i_cmd.opcode, i_cmd.x_coord, i_cmd.y_coord, next_lines);
                expected_lines.push_back(next_lines);
            end
        end
        o_pending    <= expected_lines.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top: drives commands into the scan driver, pulls results with random
// back-pressure, and gives the verdict. All prediction and comparison lives in
// lmsd_line_checker, which sits beside the block on both channels.
module tb;
    import lmsd_pkg::*;

    localparam int MAX_WAIT     = 17;
    localparam int RANDOM_ITEMS = 1550;
    // Far above the slowest legal run of the whole command sequence.
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;
    logic burst_mode;   // while set, neither side inserts idle cycles
    int   fail_count;
    int   pending;
    int   cycle_count;

    lmsd_in_if  cmd_ch ();
    lmsd_out_if line_ch ();

    led_matrix_mapped_scan_driver_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (line_ch)
    );

    lmsd_line_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_lines      (line_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_wait();
        return burst_mode ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // One command transfer: optional idle gap with valid low, then hold valid
    // until the block takes it. Returns right at the accepting edge, so a
    // back-to-back command keeps valid high without a dip.
    task automatic send_cmd(input logic [2:0] op, input logic [2:0] x, input logic [2:0] y);
        int gap;
        gap = pick_wait();
        repeat (gap) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= op;
        cmd_ch.x_coord <= x;
        cmd_ch.y_coord <= y;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
    endtask

    // Random command mix, weighted toward dot edits and ticks on the grid so the
    // scan spends most of its time running over a busy frame. The last slice is
    // raw noise: any opcode, any coordinates.
    task automatic send_random_cmd();
        int          pick;
        logic [2:0]  op;
        logic [2:0]  x;
        logic [2:0]  y;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0) begin
            x = 3'($urandom_range(0, 7));
            y = 3'($urandom_range(0, 7));
        end else begin
            x = 3'($urandom_range(0, GRID_SIDE - 1));
            y = 3'($urandom_range(0, GRID_SIDE - 1));
        end
        if      (pick < 25) op = OP_SET;
        else if (pick < 40) op = OP_CLR;
        else if (pick < 58) op = OP_TGL;
        else if (pick < 88) op = OP_TICK;
        else if (pick < 90) op = OP_CLR_ALL;
        else begin
            op = 3'($urandom);
            x  = 3'($urandom);
            y  = 3'($urandom);
        end
        send_cmd(op, x, y);
    endtask

    // Result side: per result, stall a random number of cycles, then take it.
    initial begin
        int stall;
        line_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = pick_wait();
            repeat (stall) begin
                line_ch.ready <= 1'b0;
                @(posedge i_clk);
            end
            line_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!line_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        cmd_ch.valid   <= 1'b0;
        cmd_ch.opcode  <= OP_TICK;
        cmd_ch.x_coord <= '0;
        cmd_ch.y_coord <= '0;
        burst_mode     <= 1'b0;
        i_rst_n        <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle frame first - tick and clear-all must keep lines blank.
        send_cmd(OP_TICK, 3'd0, 3'd0);
        send_cmd(OP_CLR_ALL, 3'd0, 3'd0);
        // Corner dots; setting starts the scan but lines hold until a tick.
        send_cmd(OP_SET, 3'd0, 3'd0);
        send_cmd(OP_SET, 3'd4, 3'd4);
        // Off-grid coordinates: no effect for any dot op.
        send_cmd(OP_SET, 3'd7, 3'd0);
        send_cmd(OP_SET, 3'd0, 3'd7);
        send_cmd(OP_TGL, 3'd5, 3'd5);
        send_cmd(OP_CLR, 3'd4, 3'd6);
        // Four ticks walk rows 0, 1, 2 and wrap back to 0.
        repeat (4) send_cmd(OP_TICK, 3'd0, 3'd0);
        // Opcodes past clear-all are ignored.
        for (int op = OP_CLR_ALL + 1; op < 8; op++) begin
            send_cmd(3'(op), 3'd1, 3'd1);
        end
        // Clear down to empty: scan stops and the lines blank.
        send_cmd(OP_CLR, 3'd0, 3'd0);
        send_cmd(OP_CLR, 3'd4, 3'd4);
        send_cmd(OP_TICK, 3'd0, 3'd0);
        // Toggle on restarts from the kept row; toggle off empties the frame again.
        send_cmd(OP_TGL, 3'd2, 3'd3);
        send_cmd(OP_TICK, 3'd0, 3'd0);
        send_cmd(OP_TGL, 3'd2, 3'd3);
        send_cmd(OP_TICK, 3'd0, 3'd0);
        // Set then clear-all while running.
        send_cmd(OP_SET, 3'd3, 3'd1);
        send_cmd(OP_TICK, 3'd0, 3'd0);
        send_cmd(OP_CLR_ALL, 3'd0, 3'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Switch between throttled and full-rate stretches now and then.
            if (n % 150 == 0) begin
                burst_mode <= ($urandom_range(0, 3) == 0);
            end
            send_random_cmd();
        end
        cmd_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
